[rtl/pla_pkg.sv]
// shared types, constants and helpers of the point light vertex accumulator
package pla_pkg;

    localparam int GRID_SIZE = 1024;
    localparam logic [12:0] GRID_MAX = 13'(GRID_SIZE - 1);

    localparam logic [15:0] MIN_SQ_ATTEN = 16'd7;
    localparam logic [12:0] ATTEN_ONE = 13'd4096;
    localparam logic [9:0] CH_MAX = 10'd255;

    localparam int FRONT_STAGES = 5;
    localparam int ROOT_STAGES = 17;
    localparam int ADIV_STAGES = 12;
    localparam int QDIV_STAGES = 8;
    localparam int PIPE_LAT = FRONT_STAGES + ROOT_STAGES + QDIV_STAGES + 4;

    typedef enum logic [2:0] {
        REG_LIGHT_X      = 3'd0,
        REG_LIGHT_Y      = 3'd1,
        REG_LIGHT_HEIGHT = 3'd2,
        REG_RED_GAIN     = 3'd3,
        REG_GREEN_GAIN   = 3'd4,
        REG_BLUE_GAIN    = 3'd5,
        REG_BASE_ATTEN   = 3'd6,
        REG_SQUARE_ATTEN = 3'd7
    } t_reg_idx;

    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [9:0]         vertex_x;
        logic [9:0]         vertex_y;
        logic [15:0]        vertex_height;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [23:0]        old_light;
        logic [23:0]        stored_add;
    } t_in;

    typedef struct packed {
        logic [23:0] added_light;
        logic [23:0] new_light;
    } t_out;

    typedef struct packed {
        logic [15:0] light_x;
        logic [15:0] light_y;
        logic [15:0] light_height;
        logic [7:0]  red_gain;
        logic [7:0]  green_gain;
        logic [7:0]  blue_gain;
        logic [15:0] base_atten;
        logic [15:0] square_atten;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        logic        kind;
        logic [23:0] old_light;
        logic [23:0] stored_add;
    } t_tag;

    typedef struct packed {
        t_tag               tag;
        logic [33:0]        d2;
        logic signed [35:0] dot;
        logic [50:0]        denom;
    } t_front;

    typedef struct packed {
        t_tag               tag;
        logic signed [35:0] dot;
        logic [16:0]        dlen;
        logic [12:0]        atten;
    } t_mid;

    function automatic logic [9:0] clamp_grid(logic [9:0] v);
        return ({3'b000, v} > GRID_MAX) ? GRID_MAX[9:0] : v;
    endfunction

endpackage

[rtl/point_light_vertex_accumulate.sv]
// top level of the point light vertex accumulator with its configuration registers
//
// usage
// - request channel: start with i_item (kind, vertex, normal, old and stored light);
//   a request is taken at a rising edge with start high and busy low
// - result channel: o_strobe marks o_result (added and new packed light) for one cycle;
//   the receiver cannot hold results off, and none is needed
// - configuration: i_cfg_we, i_cfg_idx, i_cfg_data write one register per edge;
//   write only while no request is in flight
// - throughput: one request per clock cycle, every cycle
// - pipeline: the result shows after the 5 front stages, the 17-stage square root
//   (one result bit per stage) and 12 back stages for products, the 8-bit
//   per-channel divide and the output
// - attenuation reciprocal: 12 quotient bits, one per stage, alongside the root
// - results leave in request order; add and remove requests share the pipe
// - reset: synchronous, clears all valid bits and loads register defaults;
//   busy is high while reset is held, low otherwise
module point_light_vertex_accumulate (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  pla_pkg::t_in      i_item,
    output logic              o_strobe,
    output pla_pkg::t_out     o_result,
    input  logic              i_cfg_we,
    input  pla_pkg::t_reg_idx i_cfg_idx,
    input  logic [15:0]       i_cfg_data
);
    import pla_pkg::*;

    t_cfg   r_cfg;
    t_front front;
    t_mid   mid;
    logic   accept;

    assign busy = ~i_rst_n;
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.light_x <= 16'd0;
            r_cfg.light_y <= 16'd0;
            r_cfg.light_height <= 16'd128;
            r_cfg.red_gain <= 8'd255;
            r_cfg.green_gain <= 8'd255;
            r_cfg.blue_gain <= 8'd255;
            r_cfg.base_atten <= 16'd410;
            r_cfg.square_atten <= 16'd2048;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LIGHT_X:      r_cfg.light_x <= i_cfg_data;
                REG_LIGHT_Y:      r_cfg.light_y <= i_cfg_data;
                REG_LIGHT_HEIGHT: r_cfg.light_height <= i_cfg_data;
                REG_RED_GAIN:     r_cfg.red_gain <= i_cfg_data[7:0];
                REG_GREEN_GAIN:   r_cfg.green_gain <= i_cfg_data[7:0];
                REG_BLUE_GAIN:    r_cfg.blue_gain <= i_cfg_data[7:0];
                REG_BASE_ATTEN:   r_cfg.base_atten <= i_cfg_data;
                REG_SQUARE_ATTEN: r_cfg.square_atten <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    pla_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (accept),
        .i_item  (i_item),
        .o_front (front)
    );

    pla_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_front (front),
        .o_mid   (mid)
    );

    pla_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_mid    (mid),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    a_req_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##PIPE_LAT o_strobe)
        else $error("request produced no result");

    a_result_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, PIPE_LAT))
        else $error("result without request");

    a_root_to_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front.tag.valid |-> ##ROOT_STAGES mid.tag.valid)
        else $error("request lost in root stages");

endmodule

[rtl/pla_front.sv]
// front stages: light vector, squares and dot terms, sums, attenuation denominator
module pla_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pla_pkg::t_cfg   i_cfg,
    input  logic            i_valid,
    input  pla_pkg::t_in    i_item,
    output pla_pkg::t_front o_front
);
    import pla_pkg::*;

    typedef struct packed {
        t_tag               tag;
        logic signed [17:0] dx;
        logic signed [17:0] dy;
        logic signed [16:0] dz;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } t_s1;

    typedef struct packed {
        t_tag               tag;
        logic [31:0]        sx;
        logic [31:0]        sy;
        logic [31:0]        sz;
        logic signed [33:0] px;
        logic signed [33:0] py;
        logic signed [33:0] pz;
    } t_s2;

    typedef struct packed {
        t_tag               tag;
        logic [33:0]        d2;
        logic signed [35:0] dot;
    } t_s3;

    typedef struct packed {
        t_tag               tag;
        logic [33:0]        d2;
        logic signed [35:0] dot;
        logic [49:0]        cd;
    } t_s4;

    t_s1    r_s1, n_s1;
    t_s2    r_s2, n_s2;
    t_s3    r_s3, n_s3;
    t_s4    r_s4, n_s4;
    t_front r_s5, n_s5;

    logic [9:0]         vx;
    logic [9:0]         vy;
    logic signed [35:0] sqx;
    logic signed [35:0] sqy;
    logic signed [33:0] sqz;
    logic [15:0]        c3;

    always_comb begin
        vx = clamp_grid(i_item.vertex_x);
        vy = clamp_grid(i_item.vertex_y);
        n_s1.tag.valid = i_valid;
        n_s1.tag.kind = i_item.kind;
        n_s1.tag.old_light = i_item.old_light;
        n_s1.tag.stored_add = i_item.stored_add;
        n_s1.dx = $signed({2'b00, i_cfg.light_x}) - $signed({2'b00, vx, 6'b000000});
        n_s1.dy = $signed({2'b00, i_cfg.light_y}) - $signed({2'b00, vy, 6'b000000});
        n_s1.dz = $signed({1'b0, i_cfg.light_height}) - $signed({1'b0, i_item.vertex_height});
        n_s1.nx = i_item.normal_x;
        n_s1.ny = i_item.normal_y;
        n_s1.nz = i_item.normal_z;
    end

    always_comb begin
        sqx = r_s1.dx * r_s1.dx;
        sqy = r_s1.dy * r_s1.dy;
        sqz = r_s1.dz * r_s1.dz;
        n_s2.tag = r_s1.tag;
        n_s2.sx = sqx[31:0];
        n_s2.sy = sqy[31:0];
        n_s2.sz = sqz[31:0];
        n_s2.px = r_s1.nx * r_s1.dx;
        n_s2.py = r_s1.ny * r_s1.dy;
        n_s2.pz = r_s1.nz * r_s1.dz;
    end

    always_comb begin
        n_s3.tag = r_s2.tag;
        n_s3.d2 = {2'b00, r_s2.sx} + {2'b00, r_s2.sy} + {2'b00, r_s2.sz};
        n_s3.dot = 36'(r_s2.px) + 36'(r_s2.py) + 36'(r_s2.pz);
    end

    always_comb begin
        c3 = (i_cfg.square_atten < MIN_SQ_ATTEN) ? MIN_SQ_ATTEN : i_cfg.square_atten;
        n_s4.tag = r_s3.tag;
        n_s4.d2 = r_s3.d2;
        n_s4.dot = r_s3.dot;
        n_s4.cd = c3 * r_s3.d2;
    end

    always_comb begin
        n_s5.tag = r_s4.tag;
        n_s5.d2 = r_s4.d2;
        n_s5.dot = r_s4.dot;
        n_s5.denom = {23'd0, i_cfg.base_atten, 12'd0} + {1'b0, r_s4.cd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
            r_s4 <= '0;
            r_s5 <= '0;
        end else begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
            r_s5 <= n_s5;
        end
    end

    assign o_front = r_s5;

endmodule

[rtl/pla_root.sv]
// pipelined square root of the squared distance and reciprocal attenuation divider
module pla_root (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pla_pkg::t_front i_front,
    output pla_pkg::t_mid   o_mid
);
    import pla_pkg::*;

    typedef enum logic [1:0] {
        AM_DIV  = 2'd0,
        AM_ONE  = 2'd1,
        AM_ZERO = 2'd2
    } t_amode;

    typedef struct packed {
        t_tag               tag;
        logic signed [35:0] dot;
        logic [33:0]        rad;
        logic [16:0]        root;
        logic [19:0]        rem;
        logic [36:0]        dvs;
        logic [36:0]        arem;
        logic [11:0]        q;
        t_amode             mode;
    } t_rs;

    t_rs prep;
    t_rs r_st [ROOT_STAGES];
    t_rs n_st [ROOT_STAGES];

    always_comb begin
        prep.tag = i_front.tag;
        prep.dot = i_front.dot;
        prep.rad = i_front.d2;
        prep.root = '0;
        prep.rem = '0;
        prep.dvs = i_front.denom[36:0];
        prep.arem = 37'h10_0000_0000;
        prep.q = '0;
        if (i_front.denom <= 51'd16777216) begin
            prep.mode = AM_ONE;
        end else if (i_front.denom > 51'h10_0000_0000) begin
            prep.mode = AM_ZERO;
        end else begin
            prep.mode = AM_DIV;
        end
    end

    for (genvar g = 0; g < ROOT_STAGES; g++) begin : g_stage
        t_rs         st_in;
        logic [19:0] rem_t;
        logic [19:0] trial;
        logic [36:0] dv_arem;
        logic [11:0] dv_q;

        if (g == 0) begin : g_first
            assign st_in = prep;
        end else begin : g_next
            assign st_in = r_st[g-1];
        end

        // one quotient bit of 2^36 / denom in each of the first stages
        if (g < ADIV_STAGES) begin : g_div
            logic [47:0] shd;
            always_comb begin
                shd = {11'd0, st_in.dvs} << (ADIV_STAGES - 1 - g);
                dv_arem = st_in.arem;
                dv_q = st_in.q;
                if ({11'd0, st_in.arem} >= shd) begin
                    dv_arem = st_in.arem - shd[36:0];
                    dv_q[ADIV_STAGES-1-g] = 1'b1;
                end
            end
        end else begin : g_nodiv
            assign dv_arem = st_in.arem;
            assign dv_q = st_in.q;
        end

        always_comb begin
            rem_t = {st_in.rem[17:0], st_in.rad[33:32]};
            trial = {1'b0, st_in.root, 2'b01};
            n_st[g] = st_in;
            n_st[g].rad = {st_in.rad[31:0], 2'b00};
            n_st[g].arem = dv_arem;
            n_st[g].q = dv_q;
            if (rem_t >= trial) begin
                n_st[g].rem = rem_t - trial;
                n_st[g].root = {st_in.root[15:0], 1'b1};
            end else begin
                n_st[g].rem = rem_t;
                n_st[g].root = {st_in.root[15:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[g] <= '0;
            end else begin
                r_st[g] <= n_st[g];
            end
        end
    end

    always_comb begin
        o_mid.tag = r_st[ROOT_STAGES-1].tag;
        o_mid.dot = r_st[ROOT_STAGES-1].dot;
        o_mid.dlen = r_st[ROOT_STAGES-1].root;
        case (r_st[ROOT_STAGES-1].mode)
            AM_ONE:  o_mid.atten = ATTEN_ONE;
            AM_ZERO: o_mid.atten = '0;
            AM_DIV:  o_mid.atten = {1'b0, r_st[ROOT_STAGES-1].q};
            default: o_mid.atten = '0;
        endcase
    end

endmodule

[rtl/pla_scale.sv]
// gain scaling, per-channel divide by distance, saturation and result register
module pla_scale (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pla_pkg::t_cfg i_cfg,
    input  pla_pkg::t_mid i_mid,
    output logic          o_strobe,
    output pla_pkg::t_out o_result
);
    import pla_pkg::*;

    typedef struct packed {
        t_tag        tag;
        logic        pos;
        logic [16:0] dlen;
        logic [47:0] num;
    } t_c1;

    typedef struct packed {
        t_tag              tag;
        logic              pos;
        logic [16:0]       dlen;
        logic [2:0][55:0]  p;
    } t_c2;

    typedef struct packed {
        t_tag              tag;
        logic              pos;
        logic [16:0]       dlen;
        logic [2:0][29:0]  rem;
        logic [2:0]        sat;
        logic [2:0][7:0]   q;
    } t_cd;

    t_c1  r_c1, n_c1;
    t_c2  r_c2, n_c2;
    t_cd  r_c3, n_c3;
    t_cd  r_dv [QDIV_STAGES];
    t_cd  n_dv [QDIV_STAGES];
    t_out r_out, n_out;
    logic r_strobe;
    logic r_kind;

    logic [2:0][7:0] gain;
    t_cd             last;
    logic [8:0]      amt9  [3];
    logic [9:0]      sum10 [3];
    logic [7:0]      old_c [3];
    logic [7:0]      amt_c [3];

    always_comb begin
        n_c1.tag = i_mid.tag;
        n_c1.pos = (i_mid.dot > 36'sd0) && (i_mid.dlen != 17'd0);
        n_c1.dlen = i_mid.dlen;
        n_c1.num = i_mid.dot[34:0] * i_mid.atten;
    end

    always_comb begin
        gain[2] = i_cfg.red_gain;
        gain[1] = i_cfg.green_gain;
        gain[0] = i_cfg.blue_gain;
        n_c2.tag = r_c1.tag;
        n_c2.pos = r_c1.pos;
        n_c2.dlen = r_c1.dlen;
        for (int c = 0; c < 3; c++) begin
            n_c2.p[c] = r_c1.num * gain[c];
        end
    end

    // a quotient of 256 or more saturates that channel anyway
    always_comb begin
        n_c3.tag = r_c2.tag;
        n_c3.pos = r_c2.pos;
        n_c3.dlen = r_c2.dlen;
        n_c3.q = '0;
        for (int c = 0; c < 3; c++) begin
            n_c3.rem[c] = r_c2.p[c][55:26];
            n_c3.sat[c] = r_c2.p[c][55:26] >= {5'd0, r_c2.dlen, 8'd0};
        end
    end

    for (genvar g = 0; g < QDIV_STAGES; g++) begin : g_div
        t_cd         st_in;
        logic [29:0] shd;

        if (g == 0) begin : g_first
            assign st_in = r_c3;
        end else begin : g_next
            assign st_in = r_dv[g-1];
        end

        always_comb begin
            shd = {13'd0, st_in.dlen} << (QDIV_STAGES - 1 - g);
            n_dv[g] = st_in;
            for (int c = 0; c < 3; c++) begin
                if (!st_in.sat[c] && (st_in.rem[c] >= shd)) begin
                    n_dv[g].rem[c] = st_in.rem[c] - shd;
                    n_dv[g].q[c][QDIV_STAGES-1-g] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[g] <= '0;
            end else begin
                r_dv[g] <= n_dv[g];
            end
        end
    end

    always_comb begin
        last = r_dv[QDIV_STAGES-1];
        for (int c = 0; c < 3; c++) begin
            old_c[c] = last.tag.old_light[8*c +: 8];
            if (!last.pos) begin
                amt9[c] = '0;
            end else if (last.sat[c]) begin
                amt9[c] = 9'd256;
            end else begin
                amt9[c] = {1'b0, last.q[c]};
            end
            sum10[c] = {1'b0, amt9[c]} + {2'b00, old_c[c]};
            if (sum10[c] > CH_MAX) begin
                amt_c[c] = 8'hFF - old_c[c];
            end else begin
                amt_c[c] = amt9[c][7:0];
            end
            n_out.added_light[8*c +: 8] = amt_c[c];
            n_out.new_light[8*c +: 8] = old_c[c] + amt_c[c];
        end
        if (last.tag.kind == KIND_REMOVE) begin
            n_out.added_light = '0;
            n_out.new_light = last.tag.old_light - last.tag.stored_add;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_out <= '0;
            r_kind <= KIND_ADD;
            r_strobe <= 1'b0;
        end else begin
            r_c1 <= n_c1;
            r_c2 <= n_c2;
            r_c3 <= n_c3;
            r_out <= n_out;
            r_kind <= last.tag.kind;
            r_strobe <= last.tag.valid;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // an add never wraps a channel
    a_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_kind == KIND_ADD) |->
            (r_out.new_light[23:16] >= r_out.added_light[23:16]) &&
            (r_out.new_light[15:8] >= r_out.added_light[15:8]) &&
            (r_out.new_light[7:0] >= r_out.added_light[7:0]))
        else $error("channel wrapped on add");

    // a saturated channel 0 sets no quotient bit in the first divider stage
    a_sat_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c3.tag.valid && r_c3.sat[0]) |=> (r_dv[0].q[0] == 8'd0))
        else $error("saturated channel produced quotient bits");

    // a facing-away or zero-distance add contributes nothing
    a_zero_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (last.tag.valid && !last.pos && last.tag.kind == KIND_ADD) |=>
            (r_out.added_light == 24'd0))
        else $error("nonzero amount without light");

endmodule
